@@ src/lbf_pkg.sv @@
package lbf_pkg;

  // Duty limits in compare counts; the accumulator holds them as 16.16.
  localparam logic [15:0] FullDuty  = 16'd1000;
  localparam logic [15:0] ZeroDuty  = 16'd0;
  localparam logic [15:0] ResetTime = 16'd500;

  localparam logic [31:0] FullFx = {FullDuty, 16'h0000};
  localparam logic [31:0] ZeroFx = {ZeroDuty, 16'h0000};

  // Ramp span; an inverted pair of limits gives no span at all.
  localparam logic [15:0] Span = (FullDuty > ZeroDuty) ? (FullDuty - ZeroDuty) : 16'd0;
  localparam logic [31:0] DivDividend = {Span, 16'h0000};

  localparam int unsigned DivSteps = 32;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_BLINK    = 2'd1,
    MODE_FADE_ON  = 2'd2,
    MODE_FADE_OFF = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    CFG_LED_MODE    = 2'd0,
    CFG_FIRST_TIME  = 2'd1,
    CFG_SECOND_TIME = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_COMMIT
  } state_e;

endpackage

@@ src/led_blink_fade_pwm_controller_top.sv @@
// LED blink / fade PWM controller. Every input transaction is one timer tick
// (restart_i = 1 forces mode entry on that tick). Every tick produces exactly one
// output transaction that carries the new PWM compare value, a written flag, the
// mode in effect after the tick and a fade-complete pulse. Blink toggles between
// full and zero duty, using a down-counter reloaded from first/second time. Fade
// on and fade off ramp the duty by a 16.16 step that is worked out once, at mode
// entry: (FULL - ZERO) << 16 divided by first_time, where a zero time counts as 1.
// The ramp clamps at its limit and then drops the block to idle. An ordinary
// tick is accepted, then updated once the output register is free. A tick that
// enters a fade mode runs the divider in between: the step comes from a radix-2
// restoring divider that yields one quotient bit per cycle through a single shared
// 17-bit subtractor. in_stall_o stays high from accept until the update is done.
// A finished result waits in the output register, so the next tick can be taken
// while the previous result is still stalled. Configuration registers
// (index 0 led_mode, 1 first_time, 2 second_time) may be written only while the
// block is idle. Writing led_mode schedules mode entry for the next tick. Writes
// to index 3 are ignored. After reset, led_mode is blink, so the first tick
// enters blink mode.
module led_blink_fade_pwm_controller_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  // tick input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        restart_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] duty_value_o,
  output logic        duty_written_o,
  output logic [1:0]  active_mode_o,
  output logic        fade_done_o
);
  import lbf_pkg::*;

  // configuration registers
  mode_e       led_mode_q, led_mode_d;
  logic [15:0] first_time_q, second_time_q;
  logic        entry_pending_q, entry_pending_d;

  // tick state
  logic [15:0] tick_cnt_q, tick_cnt_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] step_q, step_d;

  // sequencer
  state_e state_q, state_d;
  logic   entry_q;
  logic   accept, entry_now, need_div, div_last, out_free, commit;

  // divider: remainder, dividend/quotient shifter, divisor, step count
  logic [15:0]        rem_q;
  logic [31:0]        quo_q;
  logic [15:0]        dvsr_q;
  logic [DivCntW-1:0] div_cnt_q;
  logic [16:0]        trial, trial_diff;
  logic               trial_ok;

  // output register
  logic        out_valid_q, out_valid_d;
  logic [15:0] duty_value_q;
  logic        duty_written_q;
  mode_e       active_mode_q;
  logic        fade_done_q;

  // commit datapath
  logic [31:0] acc_e, step_e;
  logic        written, done;
  logic [32:0] up_sum, floor_plus;

  assign entry_now = entry_pending_q | restart_i;
  assign need_div  = entry_now &
                     ((led_mode_q == MODE_FADE_ON) | (led_mode_q == MODE_FADE_OFF));
  assign div_last  = (div_cnt_q == DivCntW'(DivSteps - 1));
  assign out_free  = ~out_valid_q | ~out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = need_div ? ST_DIV : ST_COMMIT;
        end
      end
      ST_DIV: begin
        if (div_last) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall_o = 1'b1;
    accept     = 1'b0;
    commit     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        accept     = in_valid_i;
      end
      ST_DIV:    ;
      ST_COMMIT: commit = out_free;
      default:   ;
    endcase
  end

  // one restoring step: shift in the next dividend bit, try to subtract
  assign trial      = {rem_q, quo_q[31]};
  assign trial_diff = trial - {1'b0, dvsr_q};
  assign trial_ok   = ~trial_diff[16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      entry_q   <= 1'b0;
      div_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        entry_q   <= entry_now;
        div_cnt_q <= '0;
      end else if (state_q == ST_DIV) begin
        div_cnt_q <= div_cnt_q + DivCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rem_q  <= '0;
      quo_q  <= DivDividend;
      dvsr_q <= (first_time_q == 16'd0) ? 16'd1 : first_time_q;
    end else if (state_q == ST_DIV) begin
      rem_q <= trial_ok ? trial_diff[15:0] : trial[15:0];
      quo_q <= {quo_q[30:0], trial_ok};
    end
  end

  // tick update
  always_comb begin
    acc_e      = acc_q;
    step_e     = step_q;
    tick_cnt_d = tick_cnt_q;
    written    = 1'b0;
    done       = 1'b0;
    led_mode_d = led_mode_q;

    if (entry_q) begin
      case (led_mode_q)
        MODE_BLINK: begin
          acc_e      = FullFx;
          tick_cnt_d = first_time_q;
          written    = 1'b1;
        end
        MODE_FADE_ON, MODE_FADE_OFF: begin
          acc_e      = (led_mode_q == MODE_FADE_ON) ? ZeroFx : FullFx;
          step_e     = quo_q;
          tick_cnt_d = first_time_q;
        end
        default: ;
      endcase
    end else if (led_mode_q == MODE_BLINK) begin
      if (tick_cnt_q == 16'd0) begin
        // equal limits count as full
        if (acc_q[31:16] == FullDuty) begin
          acc_e      = ZeroFx;
          tick_cnt_d = second_time_q;
        end else begin
          acc_e      = FullFx;
          tick_cnt_d = first_time_q;
        end
        written = 1'b1;
      end else begin
        tick_cnt_d = tick_cnt_q - 16'd1;
      end
    end

    up_sum     = {1'b0, acc_e} + {1'b0, step_e};
    floor_plus = {1'b0, ZeroFx} + {1'b0, step_e};
    acc_d      = acc_e;
    case (led_mode_q)
      MODE_FADE_ON: begin
        written = 1'b1;
        if (up_sum > {1'b0, FullFx}) begin
          acc_d      = FullFx;
          done       = 1'b1;
          led_mode_d = MODE_IDLE;
        end else begin
          acc_d = up_sum[31:0];
        end
      end
      MODE_FADE_OFF: begin
        written = 1'b1;
        if ({1'b0, acc_e} < floor_plus) begin
          acc_d      = ZeroFx;
          done       = 1'b1;
          led_mode_d = MODE_IDLE;
        end else begin
          acc_d = acc_e - step_e;
        end
      end
      default: ;
    endcase
    step_d = step_e;
  end

  always_comb begin
    entry_pending_d = entry_pending_q;
    if (cfg_we_i && cfg_idx_i == CFG_LED_MODE) begin
      entry_pending_d = 1'b1;
    end else if (commit) begin
      entry_pending_d = 1'b0;
    end
  end

  // configuration and tick state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_mode_q      <= MODE_BLINK;
      first_time_q    <= ResetTime;
      second_time_q   <= ResetTime;
      entry_pending_q <= 1'b1;
      tick_cnt_q      <= '0;
      acc_q           <= '0;
      step_q          <= '0;
    end else begin
      entry_pending_q <= entry_pending_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_LED_MODE:    led_mode_q    <= mode_e'(cfg_wdata_i[1:0]);
          CFG_FIRST_TIME:  first_time_q  <= cfg_wdata_i;
          CFG_SECOND_TIME: second_time_q <= cfg_wdata_i;
          default: ;
        endcase
      end else if (commit) begin
        led_mode_q <= led_mode_d;
      end
      if (commit) begin
        tick_cnt_q <= tick_cnt_d;
        acc_q      <= acc_d;
        step_q     <= step_d;
      end
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      duty_value_q   <= acc_d[31:16];
      duty_written_q <= written;
      active_mode_q  <= led_mode_d;
      fade_done_q    <= done;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign duty_value_o   = duty_value_q;
  assign duty_written_o = duty_written_q;
  assign active_mode_o  = active_mode_q;
  assign fade_done_o    = fade_done_q;

  // a new result only ever appears straight after the update cycle
  a_out_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_COMMIT)
    else $error("result appeared without an update");

  // a finished fade always leaves the block idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && fade_done_q) |-> active_mode_q == MODE_IDLE)
    else $error("fade done but mode not idle");

  // the divider runs only for fade entry
  a_div_fade: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> (entry_q &&
      (led_mode_q == MODE_FADE_ON || led_mode_q == MODE_FADE_OFF)))
    else $error("divider running outside fade entry");

endmodule

@@ tb/led_blink_fade_pwm_controller_top_tb.sv @@
module led_blink_fade_pwm_controller_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lbf_pkg::*;

  // Run bounds. The limit assumes every tick enters a fade, waits out a full sender
  // gap and several full output stalls; it is then taken a few times over.
  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned ReportMax   = 10;
  localparam int unsigned DrainCycles = 8;

  // Index past the last register; writes to it must be ignored.
  localparam logic [1:0] CfgUnused = 2'd3;

  typedef struct packed {
    logic [15:0] duty;
    logic        written;
    mode_e       mode;
    logic        done;
  } tick_result_t;

  // Clock and reset.
  logic clk_i;
  logic rst_ni = 1'b0;

  // Stimulus side. Every input is known from time zero.
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_idx   = '0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid  = 1'b0;
  logic        restart   = 1'b0;
  logic        out_stall = 1'b0;

  // Block outputs.
  logic        in_stall;
  logic        out_valid;
  logic [15:0] duty_value;
  logic        duty_written;
  logic [1:0]  active_mode;
  logic        fade_done;

  // Local copy of the controller: registers and internal state.
  mode_e       led_mode_q;
  logic [15:0] first_q;
  logic [15:0] second_q;
  mode_e       applied_q;
  logic        finished_q;
  logic [15:0] countdown_q;
  logic [31:0] duty_fx_q;
  logic [31:0] step_fx_q;
  logic        entry_due_q;

  // Duty results awaiting their output transaction, oldest first.
  tick_result_t pending_duty_q[$];

  // Idling controls: per phase, and an override for the closing back-to-back stretch.
  logic tx_calm = 1'b0;
  logic rx_calm = 1'b0;
  logic no_idle = 1'b0;

  int unsigned cycle_cnt    = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned ticks_sent   = 0;
  int unsigned restarts     = 0;
  int unsigned results_seen = 0;
  int unsigned fades_seen   = 0;
  int unsigned toggles_seen = 0;
  int unsigned setting_cnt  = 0;

  led_blink_fade_pwm_controller_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .restart_i      (restart),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .duty_value_o   (duty_value),
    .duty_written_o (duty_written),
    .active_mode_o  (active_mode),
    .fade_done_o    (fade_done)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Duty predictor
  // ---------------------------------------------------------------------------

  function automatic void reset_pwm_state();
    led_mode_q  = MODE_BLINK;
    first_q     = ResetTime;
    second_q    = ResetTime;
    applied_q   = MODE_IDLE;
    finished_q  = 1'b0;
    countdown_q = '0;
    duty_fx_q   = '0;
    step_fx_q   = '0;
    entry_due_q = 1'b1;   // first tick after reset enters blink
  endfunction

  // One timer tick: mode entry (pending write or restart), then blink or ramp update.
  function automatic tick_result_t advance_pwm(input logic restart_req);
    tick_result_t res;
    logic         entering;
    logic [32:0]  sum;
    logic [15:0]  span;
    logic [15:0]  divisor;
    mode_e        cur;
    res         = '0;
    entering    = entry_due_q | restart_req;
    cur         = led_mode_q;
    entry_due_q = 1'b0;
    if (entering) begin
      applied_q  = cur;
      finished_q = 1'b0;
      case (cur)
        MODE_BLINK: begin
          duty_fx_q   = FullFx;
          countdown_q = first_q;
          res.written = 1'b1;
        end
        MODE_FADE_ON, MODE_FADE_OFF: begin
          duty_fx_q   = (cur == MODE_FADE_ON) ? ZeroFx : FullFx;
          // inverted limits give no span, hence no step
          span        = (FullDuty > ZeroDuty) ? (FullDuty - ZeroDuty) : 16'd0;
          divisor     = (first_q == 16'd0) ? 16'd1 : first_q;
          step_fx_q   = {span, 16'h0000} / {16'h0000, divisor};
          countdown_q = first_q;
        end
        default: ;
      endcase
    end else if (cur == MODE_BLINK) begin
      if (countdown_q == 16'd0) begin
        // equal limits count as full
        if (duty_fx_q[31:16] == FullDuty) begin
          duty_fx_q   = ZeroFx;
          countdown_q = second_q;
        end else begin
          duty_fx_q   = FullFx;
          countdown_q = first_q;
        end
        res.written = 1'b1;
      end else begin
        countdown_q = countdown_q - 16'd1;
      end
    end

    // The ramp also advances on its entry tick.
    if (cur == MODE_FADE_ON) begin
      res.written = 1'b1;
      sum = {1'b0, duty_fx_q} + {1'b0, step_fx_q};
      if (sum > {1'b0, FullFx}) begin
        duty_fx_q = FullFx;
        res.done  = 1'b1;
      end else begin
        duty_fx_q = sum[31:0];
      end
    end else if (cur == MODE_FADE_OFF) begin
      res.written = 1'b1;
      sum = {1'b0, ZeroFx} + {1'b0, step_fx_q};
      if ({1'b0, duty_fx_q} < sum) begin
        duty_fx_q = ZeroFx;
        res.done  = 1'b1;
      end else begin
        duty_fx_q = duty_fx_q - step_fx_q;
      end
    end

    // A finished fade parks the block, and the mode register, in idle.
    if (res.done) begin
      finished_q = 1'b1;
      led_mode_q = MODE_IDLE;
      applied_q  = MODE_IDLE;
    end
    res.duty = duty_fx_q[31:16];
    res.mode = led_mode_q;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  function automatic void check_field(string field, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      mismatch_cnt++;
      if (mismatch_cnt <= ReportMax)
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, exp_v, act_v);
    end
  endfunction

  // Output transactions are taken at the rising edge, before any block update lands.
  always @(posedge clk_i) begin : duty_monitor
    tick_result_t exp_r;
    if (out_valid && !out_stall) begin
      if (pending_duty_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= ReportMax)
          $display("%0t ns: result transaction with nothing expected (duty %0d)",
                   $time, duty_value);
      end else begin
        exp_r = pending_duty_q.pop_front();
        check_field("duty_value", 32'(exp_r.duty), 32'(duty_value));
        check_field("duty_written", 32'(exp_r.written), 32'(duty_written));
        check_field("active_mode", 32'(exp_r.mode), 32'(active_mode));
        check_field("fade_done", 32'(exp_r.done), 32'(fade_done));
        results_seen++;
        fades_seen   += 32'(exp_r.done);
        toggles_seen += 32'(exp_r.written && exp_r.mode == MODE_BLINK);
      end
    end
  end

  // Receiver back-pressure: random stall bursts, none while calm.
  initial begin
    forever begin
      @(negedge clk_i);
      if (!(rx_calm || no_idle) && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(negedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Register write; only issued with the block drained and idle.
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_LED_MODE: begin
        led_mode_q  = mode_e'(data[1:0]);
        entry_due_q = 1'b1;
      end
      CFG_FIRST_TIME:  first_q  = data;
      CFG_SECOND_TIME: second_q = data;
      default: ;
    endcase
  endtask

  // One tick transaction. Valid is left high on return so a following tick
  // can go straight out; the prediction is queued at the accepting edge.
  task automatic send_tick(input logic restart_req);
    @(negedge clk_i);
    if (!(tx_calm || no_idle) && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    restart  <= restart_req;
    do @(posedge clk_i); while (in_stall);
    pending_duty_q.push_back(advance_pwm(restart_req));
    ticks_sent++;
    restarts += 32'(restart_req);
  endtask

  task automatic send_ticks(input int unsigned n, input logic restart_req);
    repeat (n) send_tick(restart_req);
  endtask

  // Stop sending and wait for every expected result, then let the block settle.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending_duty_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  function automatic logic [15:0] pick_time();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 14) return 16'($urandom_range(0, 12));
    if (r < 18) return 16'($urandom_range(13, 400));
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic mode_e pick_mode();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return MODE_IDLE;
    if (r < 4)  return MODE_BLINK;
    if (r < 7)  return MODE_FADE_ON;
    return MODE_FADE_OFF;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values: the first tick enters blink at full duty with a 500-tick count.
  task automatic test_reset_defaults();
    send_ticks(2, 1'b0);
    wait_drained();
  endtask

  // Zero times toggle on every tick; maximum times, entered by restart.
  task automatic test_blink_extremes();
    write_reg(CFG_FIRST_TIME, 16'd0);
    write_reg(CFG_SECOND_TIME, 16'd0);
    write_reg(CFG_LED_MODE, 16'(MODE_BLINK));
    send_ticks(4, 1'b0);
    wait_drained();
    write_reg(CFG_FIRST_TIME, 16'hFFFF);
    write_reg(CFG_SECOND_TIME, 16'hFFFF);
    send_tick(1'b1);
    send_tick(1'b0);
    wait_drained();
  endtask

  // Zero duration (treated as one tick) both ways, a short fade-on run to its
  // limit and into idle, and the longest fade-off.
  task automatic test_fade_directed();
    write_reg(CFG_FIRST_TIME, 16'd0);
    write_reg(CFG_LED_MODE, 16'(MODE_FADE_ON));
    send_ticks(3, 1'b0);
    wait_drained();
    write_reg(CFG_LED_MODE, 16'(MODE_FADE_OFF));
    send_ticks(3, 1'b0);
    wait_drained();
    write_reg(CFG_FIRST_TIME, 16'd3);
    write_reg(CFG_LED_MODE, 16'(MODE_FADE_ON));
    send_ticks(5, 1'b0);
    wait_drained();
    write_reg(CFG_FIRST_TIME, 16'hFFFF);
    write_reg(CFG_LED_MODE, 16'(MODE_FADE_OFF));
    send_ticks(2, 1'b0);
    wait_drained();
  endtask

  // Idle holds the duty even under restart; a write past the last register
  // (low bits would read as blink) must change nothing.
  task automatic test_idle_and_unused_index();
    write_reg(CFG_LED_MODE, 16'(MODE_IDLE));
    send_tick(1'b1);
    send_tick(1'b0);
    wait_drained();
    write_reg(CfgUnused, 16'hFFFD);
    send_tick(1'b1);
    wait_drained();
  endtask

  // Random settings, each followed by a burst of ticks with the odd restart.
  // Short times dominate so fades finish and blinks toggle within a burst;
  // an unwritten mode carries the previous ramp or blink across phases.
  task automatic test_random_phases(input int unsigned n_ticks);
    int unsigned target;
    int unsigned run_len;
    int unsigned k;
    target = ticks_sent + n_ticks;
    while (ticks_sent < target) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 7) write_reg(CFG_FIRST_TIME, pick_time());
      if ($urandom_range(0, 9) < 7) write_reg(CFG_SECOND_TIME, pick_time());
      if ($urandom_range(0, 9) == 0) write_reg(CfgUnused, 16'($urandom_range(0, 65535)));
      if ($urandom_range(0, 19) < 17) begin
        // upper data bits now and then, the register keeps only two
        write_reg(CFG_LED_MODE,
                  {($urandom_range(0, 3) == 0) ? 14'($urandom_range(0, 16383)) : 14'd0,
                   2'(pick_mode())});
      end
      setting_cnt++;
      run_len = $urandom_range(4, 40);
      for (k = 0; k < run_len; k++) send_tick($urandom_range(0, 15) == 0);
      // sender holds off here until every result is back
      wait_drained();
    end
  endtask

  // Closing stretch with no idling on either side.
  task automatic test_back_to_back(input int unsigned n_ticks);
    no_idle = 1'b1;
    test_random_phases(n_ticks);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    reset_pwm_state();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_blink_extremes();
    test_fade_directed();
    test_idle_and_unused_index();
    test_random_phases(1800);
    test_back_to_back(200);

    wait_drained();
    repeat (20) @(posedge clk_i);
    $display("Run: %0d ticks (%0d with restart) over %0d random settings, %0d results checked",
             ticks_sent, restarts, setting_cnt, results_seen);
    $display("Seen: %0d completed fades, %0d blink duty writes, %0d mismatches",
             fades_seen, toggles_seen, mismatch_cnt);
    if (mismatch_cnt == 0 && pending_duty_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
